### src/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants of the LED breathing PWM controller.
// ----------------------------------------------------------------------------
package lbp_pkg;

  // widths of the data paths
  localparam int unsigned CountWidth = 16;
  localparam int unsigned DutyWidth  = 16;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CmpWidth   = (CountWidth > DutyWidth) ? CountWidth : DutyWidth;

  // configuration register reset values
  localparam logic [DutyWidth-1:0] ResolutionReset = DutyWidth'(100);
  localparam logic [DutyWidth-1:0] DutyStepReset   = DutyWidth'(2);

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] RegResolution = CfgIdxWidth'(0);
  localparam logic [CfgIdxWidth-1:0] RegDutyStep   = CfgIdxWidth'(1);

  // event kinds carried by one item
  typedef enum logic [1:0] {
    EvSlot   = 2'd0,
    EvStep   = 2'd1,
    EvToggle = 2'd2,
    EvButton = 2'd3
  } kind_e;

  // one input item
  typedef struct packed {
    kind_e kind;
    logic  button_level;
  } item_t;

  // one result item
  typedef struct packed {
    logic                 first_led;
    logic                 second_led;
    logic                 breathing_led;
    logic                 active_mode;
    logic [DutyWidth-1:0] duty_level;
  } result_t;

  // configuration values seen by the core
  typedef struct packed {
    logic [DutyWidth-1:0] resolution;
    logic [DutyWidth-1:0] duty_step;
  } cfg_t;

endpackage

### src/lbp_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbp_cfg_regs
// Configuration registers: PWM resolution and duty step.
// ----------------------------------------------------------------------------
module lbp_cfg_regs import lbp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   wr_en_i,
  input  logic [CfgIdxWidth-1:0] wr_index_i,
  input  logic [DutyWidth-1:0]   wr_data_i,
  output cfg_t                   cfg_o
);

  logic [DutyWidth-1:0] resolution_q;
  logic [DutyWidth-1:0] duty_step_q;

  // register write decode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resolution_q <= ResolutionReset;
      duty_step_q  <= DutyStepReset;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        RegResolution: resolution_q <= wr_data_i;
        RegDutyStep:   duty_step_q  <= wr_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.resolution = resolution_q;
  assign cfg_o.duty_step  = duty_step_q;

endmodule

### src/lbp_in_stage.sv
// ----------------------------------------------------------------------------
// lbp_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module lbp_in_stage import lbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t item_i,
  input  logic  consume_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  logic  valid_d;
  item_t item_q;

  // free when empty or when the held item leaves this cycle
  assign in_ready_o = !valid_q || consume_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### src/lbp_core.sv
// ----------------------------------------------------------------------------
// lbp_core
// Controller state and its single-pass update for one event.
// ----------------------------------------------------------------------------
module lbp_core import lbp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    advance_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t result_o
);

  logic                  mode_q, mode_d;
  logic                  phase_q, phase_d;
  logic [DutyWidth-1:0]  duty_q, duty_d;
  logic [CountWidth-1:0] slot_q, slot_d;
  logic                  ramp_up_q, ramp_up_d;
  logic                  led_one_q, led_one_d;
  logic                  led_two_q, led_two_d;
  logic                  breath_q, breath_d;

  logic [CountWidth-1:0] slot_inc;
  logic [DutyWidth:0]    duty_sum;

  assign slot_inc = slot_q + CountWidth'(1);
  assign duty_sum = {1'b0, duty_q} + {1'b0, cfg_i.duty_step};

  // next state for the current event
  always_comb begin
    mode_d    = mode_q;
    phase_d   = phase_q;
    duty_d    = duty_q;
    slot_d    = slot_q;
    ramp_up_d = ramp_up_q;
    led_one_d = led_one_q;
    led_two_d = led_two_q;
    breath_d  = breath_q;
    unique case (item_i.kind)
      EvSlot: begin
        if (mode_q) begin
          if (CmpWidth'(slot_inc) >= CmpWidth'(cfg_i.resolution)) begin
            slot_d = '0;
          end else begin
            slot_d = slot_inc;
          end
          breath_d = CmpWidth'(slot_d) < CmpWidth'(duty_q);
        end
      end
      EvStep: begin
        if (mode_q) begin
          if (ramp_up_q) begin
            if (duty_sum >= {1'b0, cfg_i.resolution}) begin
              duty_d    = cfg_i.resolution;
              ramp_up_d = 1'b0;
            end else begin
              duty_d = duty_sum[DutyWidth-1:0];
            end
          end else begin
            if (duty_q <= cfg_i.duty_step) begin
              duty_d    = '0;
              ramp_up_d = 1'b1;
            end else begin
              duty_d = duty_q - cfg_i.duty_step;
            end
          end
        end
      end
      EvToggle: begin
        if (!mode_q) begin
          phase_d   = ~phase_q;
          led_one_d = phase_q;
          led_two_d = ~phase_q;
        end
      end
      EvButton: begin
        if (item_i.button_level) begin
          duty_d    = '0;
          slot_d    = '0;
          ramp_up_d = 1'b1;
          breath_d  = 1'b0;
          mode_d    = ~mode_q;
          if (mode_q) begin
            // back to the alternating animation
            phase_d   = 1'b0;
            led_one_d = 1'b1;
            led_two_d = 1'b0;
          end else begin
            // into breathing, alternating LEDs dark
            led_one_d = 1'b0;
            led_two_d = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b0;
      phase_q   <= 1'b0;
      duty_q    <= '0;
      slot_q    <= '0;
      ramp_up_q <= 1'b1;
      led_one_q <= 1'b1;
      led_two_q <= 1'b0;
      breath_q  <= 1'b0;
    end else if (advance_i) begin
      mode_q    <= mode_d;
      phase_q   <= phase_d;
      duty_q    <= duty_d;
      slot_q    <= slot_d;
      ramp_up_q <= ramp_up_d;
      led_one_q <= led_one_d;
      led_two_q <= led_two_d;
      breath_q  <= breath_d;
    end
  end

  // outputs as they stand after the event
  assign result_o.first_led     = led_one_d;
  assign result_o.second_led    = led_two_d;
  assign result_o.breathing_led = breath_d;
  assign result_o.active_mode   = mode_d;
  assign result_o.duty_level    = duty_d;

endmodule

### src/led_breathing_pwm_controller_unit.sv
// ----------------------------------------------------------------------------
// led_breathing_pwm_controller_unit
// Alternating-LED / PWM breathing controller driven by one event per item.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one event per item: PWM slot
// tick, breathing step tick, toggle tick or button event with its level.
// Output channel (out_valid_o/out_ready_i) returns one item per event with
// the LED drive levels, the active mode and the current duty.
// Configuration channel (cfg_valid_i/cfg_ready_o) writes resolution
// (index 0) or duty step (index 1); it is always ready and is meant to be
// used while no item is in flight.
// Path: an accepted item passes the input register, then the core logic, then
// the result register. Throughput is one item per cycle while the receiver
// takes each result; the whole state update is one pass through the core
// logic.
// Reset puts the block in toggle mode with the first LED lit, duty zero,
// both registers at their default values and both channels empty.
// A stalled receiver holds the result register; the input register then
// takes one more item and in_ready_o drops until the result is taken.
// ----------------------------------------------------------------------------
module led_breathing_pwm_controller_unit import lbp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic                   button_level_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   first_led_o,
  output logic                   second_led_o,
  output logic                   breathing_led_o,
  output logic                   active_mode_o,
  output logic [DutyWidth-1:0]   duty_level_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxWidth-1:0] cfg_index_i,
  input  logic [DutyWidth-1:0]   cfg_data_i
);

  cfg_t    cfg;
  item_t   in_item;
  item_t   held_item;
  logic    held_valid;
  logic    advance;
  result_t result;
  result_t result_q;
  logic    out_valid_q;

  assign cfg_ready_o = 1'b1;

  lbp_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_item.kind         = kind_e'(kind_i);
  assign in_item.button_level = button_level_i;

  lbp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .consume_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  // held item moves on when the result register is free
  assign advance = held_valid && (!out_valid_q || out_ready_i);

  lbp_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_item),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign first_led_o     = result_q.first_led;
  assign second_led_o    = result_q.second_led;
  assign breathing_led_o = result_q.breathing_led;
  assign active_mode_o   = result_q.active_mode;
  assign duty_level_o    = result_q.duty_level;

endmodule

### src/lbp_checker.sv
// ----------------------------------------------------------------------------
// lbp_checker
// Port-level checks of the LED breathing PWM controller, bound to the top.
// ----------------------------------------------------------------------------
module lbp_checker import lbp_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic                 first_led_o,
  input logic                 second_led_o,
  input logic                 breathing_led_o,
  input logic                 active_mode_o,
  input logic [DutyWidth-1:0] duty_level_o
);

  // a stalled item keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(duty_level_o)
      && $stable(active_mode_o) && $stable(first_led_o))
    else $error("stalled result item changed");

  // toggle mode: leds alternate, breathing side idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_mode_o |-> first_led_o != second_led_o)
    else $error("alternating leds not complementary");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !active_mode_o |-> !breathing_led_o && duty_level_o == '0)
    else $error("breathing output active in toggle mode");

  // breathing mode: alternating leds dark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && active_mode_o |-> !first_led_o && !second_led_o)
    else $error("alternating leds lit in breathing mode");

endmodule

bind led_breathing_pwm_controller_unit lbp_checker u_lbp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .first_led_o     (first_led_o),
  .second_led_o    (second_led_o),
  .breathing_led_o (breathing_led_o),
  .active_mode_o   (active_mode_o),
  .duty_level_o    (duty_level_o)
);
